FILE: hw/rtl/ksout_pkg.sv
package ksout_pkg;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_LVL_W = 3;

  localparam logic [10:0] FRAME_WIDTH_RST   = 11'd1024;
  localparam logic [10:0] FRAME_HEIGHT_RST  = 11'd1024;
  localparam logic [31:0] KEY_COLOR_RST     = 32'h00FF_00FF;
  localparam logic [31:0] OUTLINE_COLOR_RST = 32'h0000_0000;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_KEY_COLOR     = 2'd2,
    REG_OUTLINE_COLOR = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [31:0] key_color;
    logic [31:0] outline_color;
  } cfg_t;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic       key;
    logic       up_edge;
    logic       has_up;
    logic       has_own;
    logic       last_col;
  } q_entry_t;

  typedef struct packed {
    logic               valid;
    logic [Q_LVL_W-1:0] level;
  } q_stat_t;

endpackage

FILE: hw/rtl/ksout_if.sv
interface ksout_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_color;

  modport source (output valid, output pixel_color, input ready);
  modport sink   (input valid, input pixel_color, output ready);
endinterface

interface ksout_res_if;
  logic        valid;
  logic        ready;
  logic [9:0]  out_x;
  logic [9:0]  out_y;
  logic [31:0] out_color;
  logic        is_edge;
  logic        run_last;
  logic        frame_done;

  modport source (output valid, output out_x, output out_y, output out_color,
                  output is_edge, output run_last, output frame_done, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_color,
                  input is_edge, input run_last, input frame_done, output ready);
endinterface

FILE: hw/rtl/ksout_cfg.sv
module ksout_cfg
  import ksout_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= FRAME_WIDTH_RST;
      cfg_q.frame_height  <= FRAME_HEIGHT_RST;
      cfg_q.key_color     <= KEY_COLOR_RST;
      cfg_q.outline_color <= OUTLINE_COLOR_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_FRAME_WIDTH:   cfg_q.frame_width   <= pwdata[10:0];
        REG_FRAME_HEIGHT:  cfg_q.frame_height  <= pwdata[10:0];
        REG_KEY_COLOR:     cfg_q.key_color     <= pwdata;
        REG_OUTLINE_COLOR: cfg_q.outline_color <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:   prdata = {21'd0, cfg_q.frame_width};
      REG_FRAME_HEIGHT:  prdata = {21'd0, cfg_q.frame_height};
      REG_KEY_COLOR:     prdata = cfg_q.key_color;
      REG_OUTLINE_COLOR: prdata = cfg_q.outline_color;
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/ksout_front.sv
module ksout_front
  import ksout_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  ksout_pix_if.sink   pix,
  input  q_stat_t     q_stat_i,
  output logic        push_o,
  output q_entry_t    push_data_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned SW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  logic prev_mem  [MAX_WIDTH];
  logic older_mem [MAX_WIDTH];

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [SW-1:0] w_val, w_m1;
  logic [HW-1:0] h_val, h_m1;
  logic [CW-1:0] x, x_nx, x_pv;
  logic [RW-1:0] y;
  logic          last_col, first_col, y_last, key, accept;

  logic          b_valid_q;
  logic [CW-1:0] b_x_q;
  logic [9:0]    b_y_q;
  logic          b_key_q, b_last_col_q, b_first_col_q, b_y_pos_q, b_y_one_q, b_y_last_q;
  logic          prev_c_q, prev_r_q, old_c_q, old_l_q;
  logic          hit_c_q, hit_r_q, hit_l_q, fwd_key_q, fwd_cen_q;
  logic          centre, up, right, left, border, up_edge;

  always_comb begin
    if (cfg_i.frame_width == 11'd0) begin
      w_val = SW'(1);
    end else if (32'(cfg_i.frame_width) > 32'(MAX_WIDTH)) begin
      w_val = SW'(MAX_WIDTH);
    end else begin
      w_val = SW'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height == 11'd0) begin
      h_val = HW'(1);
    end else if (32'(cfg_i.frame_height) > 32'(MAX_HEIGHT)) begin
      h_val = HW'(MAX_HEIGHT);
    end else begin
      h_val = HW'(cfg_i.frame_height);
    end
    w_m1 = w_val - SW'(1);
    h_m1 = h_val - HW'(1);
    x    = (SW'(col_q) >= w_val) ? CW'(w_m1) : col_q;
    y    = (HW'(row_q) >= h_val) ? RW'(h_m1) : row_q;
    x_nx = x + CW'(1);
    x_pv = x - CW'(1);
    last_col  = (SW'(x) == w_m1);
    first_col = (x == '0);
    y_last    = (HW'(y) == h_m1);
    if (last_col) begin
      col_d = '0;
      row_d = y_last ? '0 : y + RW'(1);
    end else begin
      col_d = x_nx;
      row_d = y;
    end
  end

  assign key       = (pix.pixel_color == cfg_i.key_color);
  assign pix.ready = (q_stat_i.level + Q_LVL_W'(b_valid_q)) < Q_LVL_W'(Q_DEPTH);
  assign accept    = pix.valid && pix.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= accept;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_x_q         <= x;
      b_y_q         <= 10'(y);
      b_key_q       <= key;
      b_last_col_q  <= last_col;
      b_first_col_q <= first_col;
      b_y_pos_q     <= (y != '0);
      b_y_one_q     <= (y == RW'(1));
      b_y_last_q    <= y_last;
      hit_c_q       <= b_valid_q && (b_x_q == x);
      hit_r_q       <= b_valid_q && (b_x_q == x_nx);
      hit_l_q       <= b_valid_q && (b_x_q == x_pv);
      fwd_key_q     <= b_key_q;
      fwd_cen_q     <= centre;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_c_q <= prev_mem[x];
      prev_r_q <= prev_mem[x_nx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      old_c_q <= older_mem[x];
      old_l_q <= older_mem[x_pv];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      prev_mem[b_x_q] <= b_key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      older_mem[b_x_q] <= centre;
    end
  end

  always_comb begin
    centre  = hit_c_q ? fwd_key_q : prev_c_q;
    up      = hit_c_q ? fwd_cen_q : old_c_q;
    right   = b_last_col_q  || (hit_r_q ? fwd_key_q : prev_r_q);
    left    = b_first_col_q || (hit_l_q ? fwd_cen_q : old_l_q);
    border  = b_first_col_q || b_last_col_q || b_y_one_q;
    up_edge = !centre && (border || up || b_key_q || left || right);
  end

  assign push_o               = b_valid_q && (b_y_pos_q || b_y_last_q);
  assign push_data_o.x        = 10'(b_x_q);
  assign push_data_o.y        = b_y_q;
  assign push_data_o.key      = b_key_q;
  assign push_data_o.up_edge  = up_edge;
  assign push_data_o.has_up   = b_y_pos_q;
  assign push_data_o.has_own  = b_y_last_q;
  assign push_data_o.last_col = b_last_col_q;

endmodule

FILE: hw/rtl/ksout_queue.sv
module ksout_queue
  import ksout_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  input  logic     pop_i,
  output q_stat_t  stat_o,
  output q_entry_t head_o
);

  q_entry_t           mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_LVL_W-1:0] level_q;
  logic               do_pop;

  assign do_pop       = pop_i && (level_q != '0);
  assign stat_o.valid = (level_q != '0);
  assign stat_o.level = level_q;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      level_q <= level_q + Q_LVL_W'(push_i) - Q_LVL_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/ksout_back.sv
module ksout_back
  import ksout_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  q_stat_t     q_stat_i,
  input  q_entry_t    head_i,
  output logic        pop_o,
  ksout_res_if.source res
);

  logic        valid_q;
  logic        own_phase_q;
  logic        load, emit_up;
  logic [9:0]  x_q, y_q;
  logic [31:0] color_q;
  logic        edge_q, run_last_q, done_q;

  assign load    = (!valid_q || res.ready) && q_stat_i.valid;
  assign emit_up = head_i.has_up && !own_phase_q;
  assign pop_o   = load && (!emit_up || !head_i.has_own);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      own_phase_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q     <= 1'b1;
        own_phase_q <= emit_up && head_i.has_own;
      end else if (res.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q <= head_i.x;
      if (emit_up) begin
        y_q        <= head_i.y - 10'd1;
        edge_q     <= head_i.up_edge;
        color_q    <= head_i.up_edge ? cfg_i.outline_color : cfg_i.key_color;
        run_last_q <= !head_i.has_own;
        done_q     <= 1'b0;
      end else begin
        y_q        <= head_i.y;
        edge_q     <= !head_i.key;
        color_q    <= head_i.key ? cfg_i.key_color : cfg_i.outline_color;
        run_last_q <= 1'b1;
        done_q     <= head_i.last_col;
      end
    end
  end

  assign res.valid      = valid_q;
  assign res.out_x      = x_q;
  assign res.out_y      = y_q;
  assign res.out_color  = color_q;
  assign res.is_edge    = edge_q;
  assign res.run_last   = run_last_q;
  assign res.frame_done = done_q;

endmodule

FILE: hw/rtl/keyed_sprite_outline.sv
// Keyed sprite outline: four-neighbour boundary of a sprite in raster order.
// pix_in takes one 32-bit pixel per beat, rows of frame_width pixels,
// frame_height rows; a pixel equal to key_color is transparent.
// res_out gives one beat per output pixel: row y-1 at column x comes out
// after pixel (x, y) is taken, and pixels of the last row also give their
// own result, so a frame yields exactly width*height beats, run_last set
// on the final beat caused by each pixel and frame_done on the very last.
// Throughput is one pixel per cycle while pix_in ready is high; last-row
// pixels give two output beats each. The first result of a pixel passes
// the classifier register, the queue entry and the output register.
// A four-entry queue decouples the classifier from the output register;
// when res_out stalls the queue fills and pix_in deasserts ready.
// Registers sit on the APB port at 0x0 width, 0x4 height, 0x8 key color,
// 0xC outline color; write them only while the block is idle.
// Reset zeroes the pixel position and restores register defaults; the
// line stores need no clearing pass.
module keyed_sprite_outline
  import ksout_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ksout_pix_if.sink   pix_in,
  ksout_res_if.source res_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  q_stat_t  q_stat;
  q_entry_t push_data, head;
  logic     push, pop;

  ksout_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ksout_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pix         (pix_in),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ksout_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .stat_o      (q_stat),
    .head_o      (head)
  );

  ksout_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .q_stat_i (q_stat),
    .head_i   (head),
    .pop_o    (pop),
    .res      (res_out)
  );

endmodule
